FILE: rtl/srv_pkg.sv
`timescale 1ns / 1ps

package srv_pkg;

  // q4.20 working word, a wider word for sums before saturation, a product word
  typedef logic signed [23:0] word_t;
  typedef logic signed [27:0] wide_t;
  typedef logic signed [44:0] prod_t;
  typedef logic signed [15:0] sample_t;

  // coefficients in q.20
  localparam logic signed [35:0] Q_IN_GAIN  = 36'sd15729;
  localparam prod_t              Q_UNDAMP   = 45'sd838861;
  localparam prod_t              Q_DAMP     = 45'sd209715;
  localparam prod_t              Q_FEEDBACK = 45'sd881132;
  localparam prod_t              PROD_HALF  = 45'sd524288;

  localparam word_t W_MAX = 24'sh7FFFFF;
  localparam word_t W_MIN = 24'sh800000;

  // configuration register indexes
  localparam logic [2:0] REG_COMB_LEN_0    = 3'd0;
  localparam logic [2:0] REG_COMB_LEN_1    = 3'd1;
  localparam logic [2:0] REG_COMB_LEN_2    = 3'd2;
  localparam logic [2:0] REG_COMB_LEN_3    = 3'd3;
  localparam logic [2:0] REG_ALLPASS_LEN_0 = 3'd4;
  localparam logic [2:0] REG_ALLPASS_LEN_1 = 3'd5;

  localparam logic [13:0] COMB_LEN_0_RST    = 14'd1116;
  localparam logic [13:0] COMB_LEN_1_RST    = 14'd1188;
  localparam logic [13:0] COMB_LEN_2_RST    = 14'd1277;
  localparam logic [13:0] COMB_LEN_3_RST    = 14'd1356;
  localparam logic [11:0] ALLPASS_LEN_0_RST = 12'd556;
  localparam logic [11:0] ALLPASS_LEN_1_RST = 12'd441;

  // product rounded half up, then floor shift by 20
  function automatic wide_t rnd(input prod_t p);
    prod_t t;
    t = p + PROD_HALF;
    return wide_t'(t >>> 20);
  endfunction

  function automatic word_t sat24(input wide_t v);
    if (v > wide_t'(W_MAX)) return W_MAX;
    if (v < wide_t'(W_MIN)) return W_MIN;
    return word_t'(v);
  endfunction

  // times one half with rounding: floor((b + 1) / 2)
  function automatic wide_t half_rnd(input word_t b);
    wide_t t;
    t = wide_t'(b) + 28'sd1;
    return t >>> 1;
  endfunction

  // q4.20 to q1.15 with rounding and saturation
  function automatic sample_t to_sample(input word_t w);
    wide_t t;
    t = (wide_t'(w) + 28'sd16) >>> 5;
    if (t > 28'sd32767) return 16'sh7FFF;
    if (t < -28'sd32768) return 16'sh8000;
    return sample_t'(t);
  endfunction

endpackage

FILE: rtl/srv_ram.sv
`timescale 1ns / 1ps

module srv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when read and write hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/schroeder_reverb.sv
`timescale 1ns / 1ps

// Schroeder reverb: each dry q1.15 sample is scaled by 0.015 and fed to four
// damped comb filters, whose summed outputs pass through two allpass stages;
// the wet q1.15 result is saturated. A new sample is taken once the comb
// sequencer reaches the last of the four comb delay words of the previous
// one: the four words of a sample all go through the single write port of
// the comb delay memory. A 4-entry output queue lets the block keep taking
// samples while results wait, up to four in flight. After reset both delay
// memories are swept to zero, one entry a cycle, over max(4*COMB_DEPTH,
// 2*ALLPASS_DEPTH) entries (32768 at the defaults); dry_stall stays high
// during the sweep, configuration writes are taken as always. Delay lengths
// are written by software through cfg_we, cfg_index and cfg_data; a length
// of zero acts as one, a length above the memory depth acts as the depth,
// and lengths may only be changed while no transaction is in flight.
module schroeder_reverb import srv_pkg::*; #(
  parameter int COMB_DEPTH    = 8192,
  parameter int ALLPASS_DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  // dry sample channel
  input  logic                dry_valid,
  output logic                dry_stall,
  input  logic signed [15:0]  in_sample,
  // wet sample channel
  output logic                wet_valid,
  input  logic                wet_stall,
  output logic signed [15:0]  wet_sample
);

  // comb store: four regions of COMB_DEPTH words
  localparam int CPW = $clog2(COMB_DEPTH);
  localparam int CAW = $clog2(4 * COMB_DEPTH);
  localparam int CWW = (CPW + 1 > 14) ? CPW + 1 : 14;
  // allpass store: two regions of ALLPASS_DEPTH words
  localparam int APW = $clog2(ALLPASS_DEPTH);
  localparam int AAW = $clog2(2 * ALLPASS_DEPTH);
  localparam int AWW = (APW + 1 > 12) ? APW + 1 : 12;
  // clearing sweep covers the larger store
  localparam int CLR_N = (4 * COMB_DEPTH > 2 * ALLPASS_DEPTH) ?
                         4 * COMB_DEPTH : 2 * ALLPASS_DEPTH;
  localparam int CLW = $clog2(CLR_N + 1);

  // ---------------------------------------------------------------- config
  logic [13:0] cdly_len [4];
  logic [11:0] ap_len [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cdly_len[0] <= COMB_LEN_0_RST;
      cdly_len[1] <= COMB_LEN_1_RST;
      cdly_len[2] <= COMB_LEN_2_RST;
      cdly_len[3] <= COMB_LEN_3_RST;
      ap_len[0]   <= ALLPASS_LEN_0_RST;
      ap_len[1]   <= ALLPASS_LEN_1_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMB_LEN_0:    cdly_len[0] <= cfg_data;
        REG_COMB_LEN_1:    cdly_len[1] <= cfg_data;
        REG_COMB_LEN_2:    cdly_len[2] <= cfg_data;
        REG_COMB_LEN_3:    cdly_len[3] <= cfg_data;
        REG_ALLPASS_LEN_0: ap_len[0]   <= cfg_data[11:0];
        REG_ALLPASS_LEN_1: ap_len[1]   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- clearing sweep
  logic           clearing;
  logic [CLW-1:0] clr_cnt;
  logic           clr_comb;
  logic           clr_ap;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLW'(CLR_N - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_comb = clearing && (clr_cnt < CLW'(4 * COMB_DEPTH));
  assign clr_ap   = clearing && (clr_cnt < CLW'(2 * ALLPASS_DEPTH));

  // -------------------------------------------------------- flow control
  // credits counts transactions accepted and not yet delivered; the output
  // queue has room for all of them, so the datapath never stops
  logic       busy;
  logic [1:0] k;
  logic [2:0] credits;
  logic       acc_in;
  logic       acc_out;

  assign dry_stall = clearing || (busy && (k != 2'd3)) || (credits == 3'd4);
  assign acc_in    = dry_valid && !dry_stall;
  assign acc_out   = wet_valid && !wet_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + {2'b00, acc_in} - {2'b00, acc_out};
    end
  end

  // input scaling: x = round(s * 32 * 0.015) in q4.20
  logic signed [35:0] xin_prod;
  logic signed [35:0] xin_rnd;
  word_t              x_in;

  assign xin_prod = 36'(in_sample) * Q_IN_GAIN;
  assign xin_rnd  = ((xin_prod <<< 5) + 36'sd524288) >>> 20;

  // comb sequencer: one comb word read per cycle, k selects the comb
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (acc_in) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (busy) begin
      if (k == 2'd3) begin
        busy <= 1'b0;
      end
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      x_in <= word_t'(xin_rnd);
    end
  end

  // comb positions
  logic [CPW-1:0] cpos [4];
  logic [CWW-1:0] cpos_inc;
  logic           cpos_wrap;
  logic [CAW-1:0] c_raddr;

  assign cpos_inc  = CWW'(cpos[k]) + CWW'(1);
  // a zero length wraps at once, like length one
  assign cpos_wrap = (cpos_inc >= CWW'(cdly_len[k])) || (cpos_inc >= CWW'(COMB_DEPTH));
  assign c_raddr   = CAW'(k) * CAW'(COMB_DEPTH) + CAW'(cpos[k]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cpos[i] <= '0;
      end
    end else if (busy) begin
      cpos[k] <= cpos_wrap ? '0 : cpos_inc[CPW-1:0];
    end
  end

  // ------------------------------------------------------ comb pipeline
  // s1: delay word arrives, damping products
  // s2: new low-pass value
  // s3: feedback product
  // s4: write-back of x + feedback
  logic           v1, v2, v3, v4;
  logic [1:0]     k1, k2;
  logic [CAW-1:0] a1, a2, a3, a4;
  word_t          x1, x2, x3, x4;
  prod_t          py2, plp2, pfb4;
  word_t          lp3;
  logic           fwd1;
  word_t          fwdd1;
  word_t          lp [4];

  logic [23:0]        c_rdata;
  word_t              c_y;
  word_t              c_lpn;
  word_t              c_wdata;
  logic signed [25:0] csum;
  logic signed [25:0] csum_y;

  logic           cm_we;
  logic [CAW-1:0] cm_waddr;
  logic [23:0]    cm_wdata;

  // a write-back landing on the entry read in the same cycle is forwarded,
  // which happens when a comb length is one
  assign c_y     = fwd1 ? fwdd1 : word_t'(c_rdata);
  assign c_lpn   = sat24(rnd(py2) + rnd(plp2));
  assign c_wdata = sat24(wide_t'(x4) + rnd(pfb4));
  assign csum_y  = ((k1 == 2'd0) ? 26'sd0 : csum) + 26'(c_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      fwd1 <= 1'b0;
    end else begin
      v1   <= busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      fwd1 <= v4 && busy && (a4 == c_raddr);
    end
  end

  always_ff @(posedge clk) begin
    k1    <= k;
    a1    <= c_raddr;
    x1    <= x_in;
    fwdd1 <= c_wdata;
    k2    <= k1;
    a2    <= a1;
    x2    <= x1;
    py2   <= prod_t'(c_y) * Q_UNDAMP;
    plp2  <= prod_t'(lp[k1]) * Q_DAMP;
    a3    <= a2;
    x3    <= x2;
    lp3   <= c_lpn;
    a4    <= a3;
    x4    <= x3;
    pfb4  <= prod_t'(lp3) * Q_FEEDBACK;
    if (v1) begin
      csum <= csum_y;
    end
  end

  // low-pass registers, read in s1 and written in s2
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        lp[i] <= '0;
      end
    end else if (v2) begin
      lp[k2] <= c_lpn;
    end
  end

  assign cm_we    = clearing ? clr_comb : v4;
  assign cm_waddr = clearing ? clr_cnt[CAW-1:0] : a4;
  assign cm_wdata = clearing ? '0 : c_wdata;

  srv_ram #(
    .WIDTH (24),
    .DEPTH (4 * COMB_DEPTH)
  ) u_comb_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // comb sum of the sample, handed over after the fourth comb word
  logic  apv;
  word_t w0;

  always_ff @(posedge clk) begin
    if (rst) begin
      apv <= 1'b0;
    end else begin
      apv <= v1 && (k1 == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && (k1 == 2'd3)) begin
      w0 <= sat24(28'(csum_y));
    end
  end

  // --------------------------------------------------- allpass stages
  // b0 reads stage 0, b1 writes stage 0 and reads stage 1, b2 writes stage 1
  logic [APW-1:0] apos [2];
  logic [AWW-1:0] apos_inc0, apos_inc1;
  logic           apos_wrap0, apos_wrap1;
  logic [AAW-1:0] ap_addr0, ap_addr1;

  assign apos_inc0  = AWW'(apos[0]) + AWW'(1);
  assign apos_inc1  = AWW'(apos[1]) + AWW'(1);
  assign apos_wrap0 = (apos_inc0 >= AWW'(ap_len[0])) || (apos_inc0 >= AWW'(ALLPASS_DEPTH));
  assign apos_wrap1 = (apos_inc1 >= AWW'(ap_len[1])) || (apos_inc1 >= AWW'(ALLPASS_DEPTH));
  assign ap_addr0   = AAW'(apos[0]);
  assign ap_addr1   = AAW'(ALLPASS_DEPTH) + AAW'(apos[1]);

  logic           b1v, b2v;
  word_t          b1w, b2y;
  logic [AAW-1:0] b1a, b2a;
  logic [23:0]    ap_rdata;
  word_t          ap_y0, ap_wd0, ap_y1, ap_wd1;

  assign ap_y0  = sat24(wide_t'(word_t'(ap_rdata)) - wide_t'(b1w));
  assign ap_wd0 = sat24(wide_t'(b1w) + half_rnd(word_t'(ap_rdata)));
  assign ap_y1  = sat24(wide_t'(word_t'(ap_rdata)) - wide_t'(b2y));
  assign ap_wd1 = sat24(wide_t'(b2y) + half_rnd(word_t'(ap_rdata)));

  always_ff @(posedge clk) begin
    if (rst) begin
      apos[0] <= '0;
      apos[1] <= '0;
      b1v     <= 1'b0;
      b2v     <= 1'b0;
    end else begin
      if (apv) begin
        apos[0] <= apos_wrap0 ? '0 : apos_inc0[APW-1:0];
      end
      if (b1v) begin
        apos[1] <= apos_wrap1 ? '0 : apos_inc1[APW-1:0];
      end
      b1v <= apv;
      b2v <= b1v;
    end
  end

  always_ff @(posedge clk) begin
    b1w <= w0;
    b1a <= ap_addr0;
    b2y <= ap_y0;
    b2a <= ap_addr1;
  end

  logic           am_we;
  logic [AAW-1:0] am_waddr;
  logic [23:0]    am_wdata;
  logic [AAW-1:0] am_raddr;

  always_comb begin
    if (clearing) begin
      am_we    = clr_ap;
      am_waddr = clr_cnt[AAW-1:0];
      am_wdata = '0;
    end else if (b1v) begin
      am_we    = 1'b1;
      am_waddr = b1a;
      am_wdata = ap_wd0;
    end else begin
      am_we    = b2v;
      am_waddr = b2a;
      am_wdata = ap_wd1;
    end
  end

  assign am_raddr = b1v ? ap_addr1 : ap_addr0;

  srv_ram #(
    .WIDTH (24),
    .DEPTH (2 * ALLPASS_DEPTH)
  ) u_allpass_ram (
    .clk   (clk),
    .we    (am_we),
    .waddr (am_waddr),
    .wdata (am_wdata),
    .raddr (am_raddr),
    .rdata (ap_rdata)
  );

  // ------------------------------------------------------ output queue
  sample_t    oq [4];
  logic [1:0] oq_wp, oq_rp;
  logic [2:0] oq_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      if (b2v) begin
        oq_wp <= oq_wp + 2'd1;
      end
      if (acc_out) begin
        oq_rp <= oq_rp + 2'd1;
      end
      oq_cnt <= oq_cnt + {2'b00, b2v} - {2'b00, acc_out};
    end
  end

  always_ff @(posedge clk) begin
    if (b2v) begin
      oq[oq_wp] <= to_sample(ap_y1);
    end
  end

  assign wet_valid  = (oq_cnt != 3'd0);
  assign wet_sample = oq[oq_rp];

endmodule

FILE: tb/sv/srv_wet_checker.sv
`timescale 1ns / 1ps

module srv_wet_checker import srv_pkg::*; #(
  parameter int COMB_DEPTH    = 8192,
  parameter int ALLPASS_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [13:0]        cfg_data,
  input  logic               dry_valid,
  input  logic               dry_stall,
  input  logic signed [15:0] in_sample,
  input  logic               wet_valid,
  input  logic               wet_stall,
  input  logic signed [15:0] wet_sample,
  output int                 fail_count,
  output int                 wet_pending
);

  // q.20 coefficients
  localparam longint K_IN_GAIN  = 15729;
  localparam longint K_UNDAMP   = 838861;
  localparam longint K_DAMP     = 209715;
  localparam longint K_FEEDBACK = 881132;
  localparam longint K_HALF     = 524288;

  word_t       comb_mem [4][COMB_DEPTH];
  word_t       lowpass  [4];
  int          comb_pos [4];
  word_t       ap_mem   [2][ALLPASS_DEPTH];
  int          ap_pos   [2];
  logic [13:0] cdly_len [4];
  logic [11:0] ap_len   [2];

  sample_t     wet_expected[$];
  sample_t     want;

  // product rounded half up, floor shift by 20
  function automatic longint mul_q20(input longint a, input longint b);
    return (a * b + 64'sd524288) >>> 20;
  endfunction

  function automatic word_t clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return word_t'(v);
  endfunction

  function automatic int span(input int len, input int depth);
    if (len == 0) return 1;
    if (len > depth) return depth;
    return len;
  endfunction

  // one dry sample through combs and allpasses, updates the delay state
  function automatic sample_t wet_from_dry(input sample_t dry);
    longint x;
    longint sum;
    longint w;
    longint y;
    longint bo;
    longint o;
    int     p;
    x = clip24(mul_q20(longint'(dry) * 32, K_IN_GAIN));
    sum = 0;
    for (int c = 0; c < 4; c++) begin
      p = comb_pos[c] % COMB_DEPTH;
      y = comb_mem[c][p];
      lowpass[c] = clip24(mul_q20(y, K_UNDAMP) + mul_q20(lowpass[c], K_DAMP));
      comb_mem[c][p] = clip24(x + mul_q20(lowpass[c], K_FEEDBACK));
      comb_pos[c] = (p + 1 >= span(cdly_len[c], COMB_DEPTH)) ? 0 : p + 1;
      sum += y;
    end
    w = clip24(sum);
    for (int c = 0; c < 2; c++) begin
      p = ap_pos[c] % ALLPASS_DEPTH;
      bo = ap_mem[c][p];
      y = clip24(bo - w);
      ap_mem[c][p] = clip24(w + mul_q20(bo, K_HALF));
      ap_pos[c] = (p + 1 >= span(ap_len[c], ALLPASS_DEPTH)) ? 0 : p + 1;
      w = y;
    end
    o = (w + 16) >>> 5;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return sample_t'(o);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < COMB_DEPTH; i++) comb_mem[c][i] = '0;
        lowpass[c] = '0;
        comb_pos[c] = 0;
      end
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < ALLPASS_DEPTH; i++) ap_mem[c][i] = '0;
        ap_pos[c] = 0;
      end
      cdly_len[0] = COMB_LEN_0_RST;
      cdly_len[1] = COMB_LEN_1_RST;
      cdly_len[2] = COMB_LEN_2_RST;
      cdly_len[3] = COMB_LEN_3_RST;
      ap_len[0] = ALLPASS_LEN_0_RST;
      ap_len[1] = ALLPASS_LEN_1_RST;
      wet_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COMB_LEN_0:    cdly_len[0] = cfg_data;
          REG_COMB_LEN_1:    cdly_len[1] = cfg_data;
          REG_COMB_LEN_2:    cdly_len[2] = cfg_data;
          REG_COMB_LEN_3:    cdly_len[3] = cfg_data;
          REG_ALLPASS_LEN_0: ap_len[0] = cfg_data[11:0];
          REG_ALLPASS_LEN_1: ap_len[1] = cfg_data[11:0];
          default: ;
        endcase
      end
      if (dry_valid && !dry_stall) wet_expected.push_back(wet_from_dry(in_sample));
      if (wet_valid && !wet_stall) begin
        if (wet_expected.size() == 0) begin
          if (fail_count < 10)
            $display("%t: wet transaction with nothing expected, got %0d", $realtime,
                     wet_sample);
          fail_count++;
        end else begin
          want = wet_expected.pop_front();
          if (wet_sample !== want) begin
            if (fail_count < 10)
              $display("%t: wet_sample mismatch, expected %0d, got %0d", $realtime,
                       want, wet_sample);
            fail_count++;
          end
        end
      end
    end
    wet_pending = wet_expected.size();
  end

endmodule

FILE: tb/sv/schroeder_reverb_tb.sv
`timescale 1ns / 1ps

module schroeder_reverb_tb import srv_pkg::*; ();

  localparam int COMB_DEPTH    = 8192;
  localparam int ALLPASS_DEPTH = 2048;

  // indexes past the register list, the block must ignore writes to them
  localparam logic [2:0] NO_REG_LO = 3'd6;
  localparam logic [2:0] NO_REG_HI = 3'd7;

  // receiver behavior, switched at random intervals
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PULSE} stall_mode_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [13:0]        cfg_data  = '0;
  logic               dry_valid = 1'b0;
  logic               dry_stall;
  logic signed [15:0] in_sample = '0;
  logic               wet_valid;
  logic               wet_stall = 1'b0;
  logic signed [15:0] wet_sample;

  int          fail_count;
  int          wet_pending;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  sample_t     last_dry   = '0;
  sample_t     scripted[$];

  schroeder_reverb #(
    .COMB_DEPTH    (COMB_DEPTH),
    .ALLPASS_DEPTH (ALLPASS_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .dry_valid  (dry_valid),
    .dry_stall  (dry_stall),
    .in_sample  (in_sample),
    .wet_valid  (wet_valid),
    .wet_stall  (wet_stall),
    .wet_sample (wet_sample)
  );

  // predicts every wet sample and compares it with what comes out
  srv_wet_checker #(
    .COMB_DEPTH    (COMB_DEPTH),
    .ALLPASS_DEPTH (ALLPASS_DEPTH)
  ) wet_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dry_valid   (dry_valid),
    .dry_stall   (dry_stall),
    .in_sample   (in_sample),
    .wet_valid   (wet_valid),
    .wet_stall   (wet_stall),
    .wet_sample  (wet_sample),
    .fail_count  (fail_count),
    .wet_pending (wet_pending)
  );

  always #5 clk = ~clk;

  // receiver: stretches of free flow, random stalls, and a regular stall pulse
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   wet_stall <= 1'b0;
      STALL_RANDOM: wet_stall <= ($urandom_range(0, 99) < 35);
      default:      wet_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // scripted samples first, then a mix of full range, extremes, small values
  // and held values (a held value lets the comb feedback build up)
  function automatic sample_t next_dry();
    sample_t s;
    if (scripted.size() != 0) begin
      s = scripted.pop_front();
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        2:       s = sample_t'($urandom_range(0, 127) - 64);
        3:       s = last_dry;
        default: s = sample_t'($urandom_range(0, 65535));
      endcase
    end
    last_dry = s;
    return s;
  endfunction

  // one dry transaction; the payload is held until the block takes it
  task automatic send_sample(input sample_t s);
    dry_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (dry_stall);
  endtask

  // a run of samples in bursts, with random gaps (sometimes none) between bursts
  task automatic play(input int count);
    int burst;
    int gap;
    int i;
    burst = 0;
    for (i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 40);
      send_sample(next_dry());
      burst--;
      if (burst == 0 && i < count - 1) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          dry_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    dry_valid <= 1'b0;
  endtask

  // wait for every outstanding wet sample, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (wet_pending != 0);
    repeat (16) @(posedge clk);
  endtask

  // cfg_we stays high across a series of writes and drops after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // all six lengths plus one write to an unused index; allpass values are
  // passed as full 14-bit data so the upper two bits get dropped by the block
  task automatic set_lengths(input logic [13:0] c0, input logic [13:0] c1,
                             input logic [13:0] c2, input logic [13:0] c3,
                             input logic [13:0] a0, input logic [13:0] a1);
    write_reg(REG_COMB_LEN_0, c0);
    write_reg(REG_COMB_LEN_1, c1);
    write_reg(($urandom_range(0, 1) != 0) ? NO_REG_HI : NO_REG_LO,
              14'($urandom_range(0, 16383)));
    write_reg(REG_COMB_LEN_2, c2);
    write_reg(REG_COMB_LEN_3, c3);
    write_reg(REG_ALLPASS_LEN_0, a0);
    write_reg(REG_ALLPASS_LEN_1, a1);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset lengths: sample extremes and bit patterns; the block holds
    // dry_stall high while it clears its delay memories
    scripted = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh4000, -16'sh4000,
                 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                 16'sh0000};
    play(14);
    drain();

    // all lengths zero act as one: every comb feeds back each sample;
    // the allpass value 0x3000 keeps zero in its low 12 bits
    set_lengths(14'd0, 14'd0, 14'd0, 14'd0, 14'h3000, 14'd0);
    scripted = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sd12345, 16'sh0000};
    play(8);
    drain();

    // lengths at or past the memory depth act as the depth
    set_lengths(14'h3FFF, 14'd8192, 14'd8193, 14'd12000, 14'h3FFF, 14'h0801);
    play(300);
    drain();

    // shortened lengths while positions sit far beyond them
    set_lengths(14'd5, 14'd17, 14'd64, 14'd200, 14'd3, 14'd1);
    play(300);
    drain();

    // random short lengths, with a full drain in the middle of the stream
    set_lengths(14'($urandom_range(1, 300)), 14'($urandom_range(1, 300)),
                14'($urandom_range(1, 300)), 14'($urandom_range(1, 300)),
                {2'($urandom_range(0, 3)), 12'($urandom_range(1, 100))},
                {2'($urandom_range(0, 3)), 12'($urandom_range(1, 100))});
    play(150);
    drain();
    play(150);
    drain();

    // tiny lengths mixing zero, one, two and three
    set_lengths(14'd1, 14'd2, 14'd0, 14'd3, 14'h1002, 14'd0);
    play(200);
    drain();

    // lengths around the usual tuning
    set_lengths(14'($urandom_range(1000, 1400)), 14'($urandom_range(1000, 1400)),
                14'($urandom_range(1000, 1400)), 14'($urandom_range(1000, 1400)),
                14'($urandom_range(300, 600)), 14'($urandom_range(300, 600)));
    play(300);
    drain();

    // any 14-bit value on every register
    set_lengths(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
    play(300);
    drain();

    // extra quiet time so a stray late wet transaction is caught
    repeat (32) @(posedge clk);
    if (fail_count == 0 && wet_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: the memory sweep plus all samples take well under this
  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/srv_pkg.sv
rtl/srv_ram.sv
rtl/schroeder_reverb.sv
tb/sv/srv_wet_checker.sv
tb/sv/schroeder_reverb_tb.sv
